>>> hw/rtl/assert_macros.svh
// assertion macros shared by the filter rtl
// expects clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/tpsf_pkg.sv
// package for the topic prefix subscription filter
// command and status codes, request type and the lead byte mask; no dependencies
package tpsf_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 64;
  localparam int LEN_W    = 4;
  localparam int STATUS_W = 2;

  localparam int TOPIC_ENTRIES_DEF = 16;
  localparam int TOPIC_BYTES_DEF   = 8;

  // depth of the request queue between front and back
  localparam int Q_DEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_SUB   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNSUB = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FILT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG  = 2'd3;

  // classified request; imm requests need no table scan
  typedef struct packed {
    logic [CMD_W-1:0]    op;
    logic [KEY_W-1:0]    key;
    logic [LEN_W-1:0]    len;
    logic                imm;
    logic [STATUS_W-1:0] imm_status;
    logic                imm_deliver;
  } req_t;

  // ones over the first len bytes, counted from the msb
  function automatic logic [KEY_W-1:0] lead_mask(input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    if (len >= LEN_W'(8)) begin
      m = '1;
    end else begin
      m = ~({KEY_W{1'b1}} >> {len[2:0], 3'b000});
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/tpsf_in_if.sv
// request channel of the topic prefix subscription filter
// depends on tpsf_pkg for field widths
interface tpsf_in_if;
  logic                          valid;
  logic                          ready;
  logic [tpsf_pkg::CMD_W-1:0]    command;
  logic [tpsf_pkg::KEY_W-1:0]    key;
  logic [tpsf_pkg::LEN_W-1:0]    key_len;

  modport source (output valid, command, key, key_len, input ready);
  modport sink   (input valid, command, key, key_len, output ready);
endinterface

>>> hw/rtl/tpsf_out_if.sv
// result channel of the topic prefix subscription filter
// depends on tpsf_pkg for field widths
interface tpsf_out_if;
  logic                          valid;
  logic                          ready;
  logic [tpsf_pkg::STATUS_W-1:0] status;
  logic                          deliver;

  modport source (output valid, status, deliver, input ready);
  modport sink   (input valid, status, deliver, output ready);
endinterface

>>> hw/rtl/tpsf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module tpsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> hw/rtl/tpsf_front.sv
// front end: raw mode register, request accept and classification
// depends on tpsf_pkg and tpsf_in_if
module tpsf_front #(
  parameter int TOPIC_BYTES = tpsf_pkg::TOPIC_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  tpsf_in_if.sink             in_ch,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                q_ready,
  output logic                q_push,
  output tpsf_pkg::req_t      q_data
);

  logic raw_mode_r;
  logic raw_mode_nxt;
  logic too_long;

  assign raw_mode_nxt = cfg_we ? cfg_wdata : raw_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r <= 1'b0;
    end else begin
      raw_mode_r <= raw_mode_nxt;
    end
  end

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready;
  assign too_long    = in_ch.key_len > tpsf_pkg::LEN_W'(TOPIC_BYTES);

  always_comb begin
    q_data             = '0;
    q_data.op          = in_ch.command;
    q_data.len         = in_ch.key_len;
    q_data.key         = in_ch.key & tpsf_pkg::lead_mask(in_ch.key_len);
    q_data.imm_status  = tpsf_pkg::STATUS_OK;
    q_data.imm_deliver = 1'b0;
    case (in_ch.command)
      tpsf_pkg::CMD_SUB: begin
        q_data.imm        = too_long;
        q_data.imm_status = tpsf_pkg::STATUS_TOO_LONG;
      end
      tpsf_pkg::CMD_UNSUB: begin
        q_data.imm        = too_long;
        q_data.imm_status = tpsf_pkg::STATUS_NOT_FOUND;
      end
      tpsf_pkg::CMD_FILT: begin
        // message bytes are masked per entry in the back end
        q_data.key         = in_ch.key;
        q_data.imm         = raw_mode_r;
        q_data.imm_deliver = 1'b1;
      end
      default: begin
        q_data.imm = 1'b1;
      end
    endcase
  end

endmodule

>>> hw/rtl/tpsf_queue.sv
// short request queue between front and back end
// depends on tpsf_pkg and assert_macros.svh
`include "assert_macros.svh"

module tpsf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tpsf_pkg::req_t push_data,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output tpsf_pkg::req_t pop_data
);

  localparam int QPW = $clog2(tpsf_pkg::Q_DEPTH);
  localparam int QCW = $clog2(tpsf_pkg::Q_DEPTH + 1);

  tpsf_pkg::req_t   mem_r [tpsf_pkg::Q_DEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;

  function automatic logic [QPW-1:0] ptr_inc(input logic [QPW-1:0] p);
    return (p == QPW'(tpsf_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = count_r != QCW'(tpsf_pkg::Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_RST(a_no_overflow, push |-> (count_r != QCW'(tpsf_pkg::Q_DEPTH)), "queue overflow")
  `ASSERT_RST(a_no_underflow, pop |-> (count_r != '0), "queue underflow")

endmodule

>>> hw/rtl/tpsf_back.sv
// back end: scans the topic table one entry a cycle, applies the change, holds the result
// depends on tpsf_pkg, tpsf_out_if, tpsf_ram and assert_macros.svh
`include "assert_macros.svh"

module tpsf_back #(
  parameter int TOPIC_ENTRIES = tpsf_pkg::TOPIC_ENTRIES_DEF,
  parameter int TOPIC_BYTES   = tpsf_pkg::TOPIC_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  tpsf_pkg::req_t q_data,
  output logic           q_pop,
  tpsf_out_if.source     out_ch
);

  localparam int W  = 8 * TOPIC_BYTES;
  localparam int LW = $clog2(TOPIC_BYTES + 1);
  localparam int IW = $clog2(TOPIC_ENTRIES);
  localparam int CW = $clog2(TOPIC_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  tpsf_pkg::req_t                  work_r, work_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic                            rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]                   rd_idx_r, rd_idx_nxt;
  logic                            rd_used_r, rd_used_nxt;
  logic                            hit_r, hit_nxt;
  logic [IW-1:0]                   hit_idx_r, hit_idx_nxt;
  logic                            free_found_r, free_found_nxt;
  logic [IW-1:0]                   free_idx_r, free_idx_nxt;
  logic [TOPIC_ENTRIES-1:0]        valid_r, valid_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [tpsf_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic                            out_deliver_r, out_deliver_nxt;

  logic                            issue;
  logic [IW-1:0]                   raddr;
  logic [W+LW-1:0]                 ram_rdata;
  logic                            ram_we;
  logic [W+LW-1:0]                 ram_wdata;
  logic [W-1:0]                    rd_bytes;
  logic [LW-1:0]                   rd_len;
  logic [W-1:0]                    key_top;
  logic [tpsf_pkg::KEY_W-1:0]      ent_mask;
  logic                            exact, prefix, match;
  logic                            out_free;
  logic                            finish;
  logic                            clr_we;
  logic [tpsf_pkg::STATUS_W-1:0]   res_status;
  logic                            res_deliver;

  assign issue     = (state_r == ST_SCAN) && (cnt_r < CW'(TOPIC_ENTRIES));
  assign raddr     = cnt_r[IW-1:0];
  assign rd_bytes  = ram_rdata[W-1:0];
  assign rd_len    = ram_rdata[W+LW-1:W];
  assign key_top   = work_r.key[tpsf_pkg::KEY_W-1 -: W];
  assign ent_mask  = tpsf_pkg::lead_mask(tpsf_pkg::LEN_W'(rd_len));
  assign exact     = (tpsf_pkg::LEN_W'(rd_len) == work_r.len) && (rd_bytes == key_top);
  assign prefix    = (tpsf_pkg::LEN_W'(rd_len) <= work_r.len) &&
                     ((key_top & ent_mask[tpsf_pkg::KEY_W-1 -: W]) == rd_bytes);
  assign match     = (work_r.op == tpsf_pkg::CMD_FILT) ? prefix : exact;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign finish    = (state_r == ST_FINISH) && out_free;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign ram_wdata = {work_r.len[LW-1:0], key_top};

  tpsf_ram #(
    .WIDTH (W + LW),
    .DEPTH (TOPIC_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // outcome of the request once the scan is done
  always_comb begin
    res_status  = tpsf_pkg::STATUS_OK;
    res_deliver = 1'b0;
    ram_we      = 1'b0;
    clr_we      = 1'b0;
    if (work_r.imm) begin
      res_status  = work_r.imm_status;
      res_deliver = work_r.imm_deliver;
    end else begin
      case (work_r.op)
        tpsf_pkg::CMD_SUB: begin
          if (!hit_r) begin
            if (free_found_r) begin
              ram_we = finish;
            end else begin
              res_status = tpsf_pkg::STATUS_FULL;
            end
          end
        end
        tpsf_pkg::CMD_UNSUB: begin
          if (hit_r) begin
            clr_we = finish;
          end else begin
            res_status = tpsf_pkg::STATUS_NOT_FOUND;
          end
        end
        tpsf_pkg::CMD_FILT: begin
          res_deliver = hit_r;
        end
        default: begin
          res_status = tpsf_pkg::STATUS_OK;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    work_nxt        = work_r;
    cnt_nxt         = cnt_r;
    rd_vld_nxt      = issue;
    rd_idx_nxt      = raddr;
    rd_used_nxt     = valid_r[raddr];
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    valid_nxt       = valid_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_deliver_nxt = out_deliver_r;

    // compare stage, on the ram data read from the previous cycle's address
    if (rd_vld_r) begin
      if (rd_used_r && match && !hit_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = rd_idx_r;
      end
      if (!rd_used_r && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = rd_idx_r;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          work_nxt       = q_data;
          cnt_nxt        = '0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = q_data.imm ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          // last compare lands this cycle
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status;
          out_deliver_nxt = res_deliver;
          state_nxt       = ST_IDLE;
          if (ram_we) begin
            valid_nxt[free_idx_r] = 1'b1;
          end
          if (clr_we) begin
            valid_nxt[hit_idx_r] = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r        <= work_nxt;
    cnt_r         <= cnt_nxt;
    rd_idx_r      <= rd_idx_nxt;
    rd_used_r     <= rd_used_nxt;
    hit_r         <= hit_nxt;
    hit_idx_r     <= hit_idx_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    out_status_r  <= out_status_nxt;
    out_deliver_r <= out_deliver_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.deliver = out_deliver_r;

  `ASSERT_RST(a_write_free_slot, ram_we |-> !valid_r[free_idx_r], "subscribe overwrites a used entry")
  `ASSERT_RST(a_compare_in_scan, rd_vld_r |-> (state_r == ST_SCAN || state_r == ST_FINISH), "compare outside a scan")
  `ASSERT_RST(a_one_change, !(ram_we && clr_we), "insert and remove in the same request")

endmodule

>>> hw/rtl/topic_prefix_subscription_filter.sv
// Topic prefix subscription filter: a table of up to TOPIC_ENTRIES topics of up to
// TOPIC_BYTES bytes, driven by subscribe, unsubscribe and filter requests, one result per
// request. Subscribe, unsubscribe and filter without raw mode scan the topic ram one entry
// per cycle; over-long topics, raw mode filters and the unused command skip the scan. A
// two-entry request queue lets new requests in while the table is busy, and the result
// register holds a result until it is taken. The user must write raw_mode through
// cfg_we/cfg_wdata only while no request is in flight; the block does not enforce this.
// Reset is synchronous and clears the entry valid bits at once, with no clearing pass.
// depends on tpsf_pkg, the channel interfaces, tpsf_front, tpsf_queue and tpsf_back
module topic_prefix_subscription_filter #(
  parameter int TOPIC_ENTRIES = tpsf_pkg::TOPIC_ENTRIES_DEF,
  parameter int TOPIC_BYTES   = tpsf_pkg::TOPIC_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tpsf_in_if.sink     in_ch,
  tpsf_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic           q_push;
  logic           q_ready;
  tpsf_pkg::req_t q_push_data;
  logic           q_pop;
  logic           q_valid;
  tpsf_pkg::req_t q_pop_data;

  tpsf_front #(
    .TOPIC_BYTES (TOPIC_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  tpsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_pop_data)
  );

  tpsf_back #(
    .TOPIC_ENTRIES (TOPIC_ENTRIES),
    .TOPIC_BYTES   (TOPIC_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> tb/topic_prefix_subscription_filter_test.sv
`timescale 1ns / 100ps
// self-checking bench for topic_prefix_subscription_filter: random subscribe, unsubscribe and
// filter requests checked against a scoreboard that mirrors the topic table
// depends on tpsf_pkg, tpsf_in_if, tpsf_out_if and the filter rtl
module topic_prefix_subscription_filter_test;
  import tpsf_pkg::*;

  localparam int LATENCY     = TOPIC_ENTRIES_DEF + 3;
  localparam int LIMIT       = 1000000;
  localparam int LONG_HOLD   = 300;
  localparam int POOL_SIZE   = 32;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 246;

  typedef enum {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;

  // mirror of the topic table plus the results still owed by the block
  class filter_scoreboard;
    localparam int ENTRIES = TOPIC_ENTRIES_DEF;
    localparam int MAX_LEN = TOPIC_BYTES_DEF;

    typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                deliver;
    } verdict_t;

    logic [KEY_W-1:0] topic_key [ENTRIES];
    logic [LEN_W-1:0] topic_len [ENTRIES];
    bit               in_use    [ENTRIES];
    bit               raw_mode;
    verdict_t         awaited[$];
    int unsigned      errors;

    function new();
      foreach (in_use[i]) in_use[i] = 1'b0;
      raw_mode = 1'b0;
      errors   = 0;
    endfunction

    function logic [KEY_W-1:0] byte_window(int unsigned n);
      logic [KEY_W-1:0] m;
      m = '0;
      for (int b = 0; b < 8; b++)
        if (b < n) m[KEY_W-1-8*b -: 8] = 8'hff;
      return m;
    endfunction

    function int find_topic(logic [KEY_W-1:0] bytes, logic [LEN_W-1:0] len);
      for (int i = 0; i < ENTRIES; i++)
        if (in_use[i] && topic_len[i] == len && topic_key[i] == bytes) return i;
      return -1;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_request(logic [CMD_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [LEN_W-1:0] len);
      verdict_t         v;
      logic [KEY_W-1:0] trimmed;
      int               hit;
      int               spare;
      v = '0;
      trimmed = key & byte_window(len);
      case (op)
        CMD_SUB: begin
          if (len > MAX_LEN) begin
            v.status = STATUS_TOO_LONG;
          end else if (find_topic(trimmed, len) < 0) begin
            spare = -1;
            // lowest free slot wins
            for (int i = ENTRIES - 1; i >= 0; i--)
              if (!in_use[i]) spare = i;
            if (spare < 0) begin
              v.status = STATUS_FULL;
            end else begin
              in_use[spare]    = 1'b1;
              topic_key[spare] = trimmed;
              topic_len[spare] = len;
            end
          end
        end
        CMD_UNSUB: begin
          v.status = STATUS_NOT_FOUND;
          if (len <= MAX_LEN) begin
            hit = find_topic(trimmed, len);
            if (hit >= 0) begin
              in_use[hit] = 1'b0;
              v.status    = STATUS_OK;
            end
          end
        end
        CMD_FILT: begin
          if (raw_mode) begin
            v.deliver = 1'b1;
          end else begin
            for (int i = 0; i < ENTRIES; i++)
              if (in_use[i] && topic_len[i] <= len &&
                  (key & byte_window(topic_len[i])) == topic_key[i]) v.deliver = 1'b1;
          end
        end
        default: ;
      endcase
      awaited.push_back(v);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic deliver);
      verdict_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual status %0d deliver %0b",
                 $time, status, deliver);
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
      end
      if (deliver !== want.deliver) begin
        errors++;
        $display("%0t: deliver expected %0b actual %0b", $time, want.deliver, deliver);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  tpsf_in_if  in_ch();
  tpsf_out_if out_ch();

  filter_scoreboard board;
  int unsigned      cycle_count = 0;
  bit               steady = 1'b0;
  bit               hold_pending = 1'b0;
  logic [KEY_W-1:0] pool_key [POOL_SIZE];
  logic [LEN_W-1:0] pool_len [POOL_SIZE];

  topic_prefix_subscription_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.status, out_ch.deliver);
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // small alphabet so that topics share prefixes
  function automatic logic [7:0] alpha_byte();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = 8'h00;
      1:       c = 8'hff;
      2:       c = 8'h2f;
      default: c = 8'h61;
    endcase
    return c;
  endfunction

  // result side: random stalls, one long hold when asked
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [LEN_W-1:0] len);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= op;
    in_ch.key     <= key;
    in_ch.key_len <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_request(op, key, len);
    @(negedge clk);
  endtask

  task automatic write_raw(input bit value);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we         <= 1'b0;
    board.raw_mode = value;
  endtask

  task automatic random_request(input mix_t mix);
    int unsigned      r;
    int unsigned      t;
    int unsigned      sub_cut;
    int unsigned      unsub_cut;
    int unsigned      msg_len;
    logic [CMD_W-1:0] op;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    case (mix)
      MIX_FILL:  begin sub_cut = 55; unsub_cut = 65; end
      MIX_EVEN:  begin sub_cut = 30; unsub_cut = 55; end
      default:   begin sub_cut = 12; unsub_cut = 55; end
    endcase
    r   = $urandom_range(0, 99);
    t   = $urandom_range(0, POOL_SIZE - 1);
    key = {$urandom, $urandom};
    len = LEN_W'($urandom_range(0, 15));
    if (r >= 94) begin
      // noise, unused command included
      op = CMD_W'($urandom_range(0, 3));
    end else if (r < unsub_cut) begin
      op = (r < sub_cut) ? CMD_SUB : CMD_UNSUB;
      r  = $urandom_range(0, 99);
      if (r < 85) begin
        len = pool_len[t];
        key = (pool_key[t] & board.byte_window(len)) | (key & ~board.byte_window(len));
      end else if (r < 95) begin
        len = LEN_W'($urandom_range(TOPIC_BYTES_DEF + 1, 15));
      end
    end else begin
      op = CMD_FILT;
      r  = $urandom_range(0, 99);
      if (r < 80) begin
        if (r < 65 || pool_len[t] == 0) msg_len = $urandom_range(pool_len[t], 15);
        else msg_len = $urandom_range(0, pool_len[t] - 1);
        len = LEN_W'(msg_len);
        key = pool_key[t];
        for (int b = 0; b < 8; b++)
          if (b >= pool_len[t]) key[63-8*b -: 8] = (b < msg_len) ? alpha_byte() : 8'($urandom);
      end
    end
    send_request(op, key, len);
  endtask

  initial begin
    mix_t mix;
    board         = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_SUB;
    in_ch.key     = '0;
    in_ch.key_len = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_raw(1'b0);

    send_request(CMD_FILT,  '1, 4'd15);                      // empty table
    send_request(CMD_SUB,   64'h0123_4567_89ab_cdef, 4'd9);  // too long
    send_request(CMD_UNSUB, '1, 4'd15);                      // too long, so not found
    send_request(CMD_SUB,   64'h2f61_dead_beef_5555, 4'd2);  // junk past the length
    send_request(CMD_SUB,   64'h2f61_0000_0000_0000, 4'd2);  // duplicate
    send_request(CMD_FILT,  64'h2f61_6200_0000_0000, 4'd3);
    send_request(CMD_FILT,  64'h2f61_0000_0000_0000, 4'd1);  // message shorter than topic
    send_request(CMD_FILT,  64'h2f62_ffff_ffff_ffff, 4'd15);
    send_request(CMD_SUB,   '1, 4'd8);
    send_request(CMD_FILT,  '1, 4'd8);
    send_request(CMD_FILT,  64'hffff_ffff_ffff_fffe, 4'd15);
    send_request(CMD_NONE,  '1, 4'd15);
    send_request(CMD_UNSUB, 64'h2f61_7777_0000_0000, 4'd2);
    send_request(CMD_UNSUB, 64'h2f61_0000_0000_0000, 4'd2);
    send_request(CMD_UNSUB, '1, 4'd7);                       // length differs
    send_request(CMD_SUB,   '1, 4'd0);                       // empty topic
    send_request(CMD_FILT,  64'h0, 4'd0);
    send_request(CMD_UNSUB, 64'h0, 4'd0);
    send_request(CMD_UNSUB, '1, 4'd8);
    send_request(CMD_FILT,  '1, 4'd15);

    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_len[p] = ($urandom_range(0, 31) == 0) ? 4'd0
                    : LEN_W'($urandom_range(1, $urandom_range(1, TOPIC_BYTES_DEF)));
      pool_key[p] = '0;
      for (int b = 0; b < 8; b++)
        if (b < pool_len[p]) pool_key[p][63-8*b -: 8] = alpha_byte();
    end

    for (int p = 0; p < PHASES; p++) begin
      write_raw(p == 1 || p == 4);
      steady = (p == 1);
      if (p == 2) hold_pending = 1'b1;
      if (p == 1) mix = MIX_EVEN;
      else if (p == 3) mix = MIX_DRAIN;
      else mix = MIX_FILL;
      for (int n = 0; n < PHASE_ITEMS; n++) random_request(mix);
    end

    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (2 * LATENCY) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> topic_prefix_subscription_filter.f
+incdir+hw/rtl
hw/rtl/tpsf_pkg.sv
hw/rtl/tpsf_in_if.sv
hw/rtl/tpsf_out_if.sv
hw/rtl/tpsf_ram.sv
hw/rtl/tpsf_front.sv
hw/rtl/tpsf_queue.sv
hw/rtl/tpsf_back.sv
hw/rtl/topic_prefix_subscription_filter.sv
tb/topic_prefix_subscription_filter_test.sv
